[rtl/pva_pkg.sv]
// shared types, constants and lookup tables of the voice allocator
`default_nettype none

package pva_pkg;

    // field widths
    localparam int VOICE_W = 6;
    localparam int NOTE_W  = 7;
    localparam int VEL_W   = 7;
    localparam int FREQ_W  = 30;
    localparam int GAIN_W  = 16;

    // default voice count
    localparam int VOICES_DEF = 64;

    // event kinds
    localparam logic ACT_NOTE_ON  = 1'b0;
    localparam logic ACT_NOTE_OFF = 1'b1;

    // command word between front and back
    typedef struct packed {
        logic              action;
        logic [NOTE_W-1:0] note;
        logic [FREQ_W-1:0] freq;
        logic [GAIN_W-1:0] gain;
    } pva_cmd_t;

    typedef logic [FREQ_W-1:0] freq_rom_t [128];
    typedef logic [GAIN_W-1:0] gain_rom_t [128];
    typedef logic [63:0]       base_rom_t [12];

    // frequency of keys 69..80 in units of 2^-24 Hz
    localparam base_rom_t BASE_Q24 = '{
        64'd7381975040,  64'd7820930118,  64'd8285986824,  64'd8778697240,
        64'd9300705743,  64'd9853754486,  64'd10439689219, 64'd11060465444,
        64'd11718154944, 64'd12414952697, 64'd13153184201, 64'd13935313234
    };

    // key frequency in Q14.16, octave shift of the base table with rounding
    function automatic freq_rom_t make_freq_rom();
        freq_rom_t   rom;
        int unsigned m;
        int unsigned k;
        int unsigned s;
        logic [63:0] v;
        for (int n = 0; n < 128; n++)
        begin
            m = n + 3;
            k = m % 12;
            s = 14 - m / 12;
            v = (BASE_Q24[k[3:0]] + (64'd1 << (s - 1))) >> s;
            rom[n[6:0]] = v[FREQ_W-1:0];
        end
        return rom;
    endfunction

    // velocity gain in Q1.15, rounded
    function automatic gain_rom_t make_gain_rom();
        gain_rom_t   rom;
        int unsigned g;
        for (int i = 0; i < 128; i++)
        begin
            g = (i * 32768 + 63) / 127;
            rom[i[6:0]] = g[GAIN_W-1:0];
        end
        return rom;
    endfunction

    localparam freq_rom_t FREQ_ROM = make_freq_rom();
    localparam gain_rom_t GAIN_ROM = make_gain_rom();

endpackage

`default_nettype wire

[rtl/polyphonic_voice_allocator.sv]
// polyphonic voice allocator: MIDI note events in, voice start and release words out
//
// Input channel (in_valid/in_ready) takes one event word: action, note, velocity.
// Output channel (out_valid/out_ready) gives voice start or release words; last
// marks the final word of an event. A note-on with velocity gives one start word
// (voice, gate 1, freq_q16, gain_q15) when a free voice exists, else nothing; a
// zero velocity note-on gives nothing. A note-off gives one release word per
// voice holding that note, in voice index order, or nothing.
// An input stage and a two-word command queue sit in front of the voice engine,
// so new events are taken while the engine works or a result waits.
// An accepted note-on reaches its start word through the input stage register, a
// queue entry, the free list read and the result register. A note-off occupies the
// engine for the scan of the voice note memory, one entry per cycle through its
// single read port unless a match waits on a full result register.
// When the receiver stalls, the result register holds and the engine waits.
// Reset: all voices free in index order, none sounding; ready right after reset,
// with no clearing pass.
`default_nettype none

module polyphonic_voice_allocator
#(
    parameter int VOICES = pva_pkg::VOICES_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        action,
    input  wire logic [pva_pkg::NOTE_W-1:0]  note,
    input  wire logic [pva_pkg::VEL_W-1:0]   velocity,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pva_pkg::VOICE_W-1:0]      voice,
    output logic                             gate,
    output logic [pva_pkg::FREQ_W-1:0]       freq_q16,
    output logic [pva_pkg::GAIN_W-1:0]       gain_q15,
    output logic                             last
);
    import pva_pkg::*;

    pva_cmd_t front_cmd;
    logic     front_valid;
    logic     front_ready;
    pva_cmd_t queue_cmd;
    logic     queue_valid;
    logic     queue_ready;

    // input stage
    pva_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .note      (note),
        .velocity  (velocity),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    // command queue
    pva_cmd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_cmd   (front_cmd),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_cmd   (queue_cmd)
    );

    // voice engine
    pva_back #(
        .VOICES (VOICES)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .voice     (voice),
        .gate      (gate),
        .freq_q16  (freq_q16),
        .gain_q15  (gain_q15),
        .last      (last)
    );

endmodule

`default_nettype wire

[rtl/pva_front.sv]
// input stage: takes event words, drops silent note-ons, looks up freq and gain
`default_nettype none

module pva_front
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      action,
    input  wire logic [pva_pkg::NOTE_W-1:0] note,
    input  wire logic [pva_pkg::VEL_W-1:0]  velocity,
    output logic                           cmd_valid,
    input  wire logic                      cmd_ready,
    output pva_pkg::pva_cmd_t              cmd
);
    import pva_pkg::*;

    logic     hold_vld_reg;
    logic     hold_vld_next;
    pva_cmd_t hold_reg;
    pva_cmd_t hold_next;
    logic     accept;
    logic     keep;

    // stage frees up when its word moves on
    assign in_ready  = !hold_vld_reg || cmd_ready;
    assign accept    = in_valid && in_ready;
    assign cmd_valid = hold_vld_reg;
    assign cmd       = hold_reg;

    // zero velocity note-on causes nothing
    assign keep = (action == ACT_NOTE_OFF) || (velocity != '0);

    always_comb
    begin
        hold_vld_next = hold_vld_reg && !cmd_ready;
        hold_next     = hold_reg;
        if (accept)
        begin
            hold_vld_next    = keep;
            hold_next.action = action;
            hold_next.note   = note;
            hold_next.freq   = FREQ_ROM[note];
            hold_next.gain   = GAIN_ROM[velocity];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

[rtl/pva_cmd_queue.sv]
// two-entry command queue between the input stage and the voice engine
`default_nettype none

module pva_cmd_queue
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_valid,
    output logic                   wr_ready,
    input  pva_pkg::pva_cmd_t      wr_cmd,
    output logic                   rd_valid,
    input  wire logic              rd_ready,
    output pva_pkg::pva_cmd_t      rd_cmd
);
    import pva_pkg::*;

    pva_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_cmd   = entry_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

`default_nettype wire

[rtl/pva_back.sv]
// voice engine: free list, voice note table, note-off scan and result register
`default_nettype none

module pva_back
#(
    parameter int VOICES = pva_pkg::VOICES_DEF
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cmd_valid,
    output logic                             cmd_ready,
    input  pva_pkg::pva_cmd_t                cmd,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [pva_pkg::VOICE_W-1:0]      voice,
    output logic                             gate,
    output logic [pva_pkg::FREQ_W-1:0]       freq_q16,
    output logic [pva_pkg::GAIN_W-1:0]       gain_q15,
    output logic                             last
);
    import pva_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CNT_W = $clog2(VOICES + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(VOICES - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(VOICES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ON_EMIT,
        ST_OFF_SCAN,
        ST_OFF_FLUSH
    } state_t;

    // memories
    logic [IDX_W-1:0]  fifo_mem [VOICES];
    logic [NOTE_W-1:0] note_mem [VOICES];
    logic [IDX_W-1:0]  fifo_q_reg;
    logic [NOTE_W-1:0] note_q_reg;

    // control state
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic              wrap_reg, wrap_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [VOICES-1:0] valid_reg, valid_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              issued_reg, issued_next;
    logic              cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              pend_vld_reg, pend_vld_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [VOICE_W-1:0] voice_reg, voice_next;
    logic               gate_reg, gate_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic [GAIN_W-1:0]  gain_reg, gain_next;
    logic               last_reg, last_next;

    // memory strobes
    logic              fifo_rd_en;
    logic              push_en;
    logic              note_wr_en;
    logic              note_rd_en;
    logic [IDX_W-1:0]  pop_voice;
    logic              slot_free;
    logic              hit;
    logic              stall;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
        return (x == LAST_IDX) ? '0 : x + 1'b1;
    endfunction

    assign slot_free = !out_valid_reg || out_ready;

    // free list slots never written stand for the voice equal to the slot
    assign pop_voice = (wrap_reg || (head_reg < tail_reg)) ? fifo_q_reg : head_reg;

    // compare stage of the note-off scan
    assign hit   = cmp_vld_reg && valid_reg[cmp_idx_reg] && (note_q_reg == cmd.note);
    assign stall = hit && pend_vld_reg && !slot_free;

    // next state and results
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        wrap_next      = wrap_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        rd_idx_next    = rd_idx_reg;
        issued_next    = issued_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        voice_next     = voice_reg;
        gate_next      = gate_reg;
        freq_next      = freq_reg;
        gain_next      = gain_reg;
        last_next      = last_reg;
        fifo_rd_en     = 1'b0;
        push_en        = 1'b0;
        note_wr_en     = 1'b0;
        note_rd_en     = 1'b0;
        cmd_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.action == ACT_NOTE_ON)
                    begin
                        if (count_reg == '0)
                        begin
                            cmd_ready = 1'b1;
                        end
                        else
                        begin
                            fifo_rd_en = 1'b1;
                            state_next = ST_ON_EMIT;
                        end
                    end
                    else
                    begin
                        rd_idx_next   = '0;
                        issued_next   = 1'b0;
                        cmp_vld_next  = 1'b0;
                        pend_vld_next = 1'b0;
                        state_next    = ST_OFF_SCAN;
                    end
                end
            end

            ST_ON_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next        = 1'b1;
                    voice_next            = VOICE_W'(pop_voice);
                    gate_next             = 1'b1;
                    freq_next             = cmd.freq;
                    gain_next             = cmd.gain;
                    last_next             = 1'b1;
                    valid_next[pop_voice] = 1'b1;
                    note_wr_en            = 1'b1;
                    head_next             = idx_inc(head_reg);
                    count_next            = count_reg - 1'b1;
                    cmd_ready             = 1'b1;
                    state_next            = ST_IDLE;
                end
            end

            ST_OFF_SCAN:
            begin
                if (!stall)
                begin
                    // release a matching voice, earlier match goes out as not last
                    if (hit)
                    begin
                        valid_next[cmp_idx_reg] = 1'b0;
                        if (count_reg < FULL_CNT)
                        begin
                            push_en    = 1'b1;
                            tail_next  = idx_inc(tail_reg);
                            count_next = count_reg + 1'b1;
                            if (tail_reg == LAST_IDX)
                            begin
                                wrap_next = 1'b1;
                            end
                        end
                        if (pend_vld_reg)
                        begin
                            out_valid_next = 1'b1;
                            voice_next     = VOICE_W'(pend_idx_reg);
                            gate_next      = 1'b0;
                            freq_next      = '0;
                            gain_next      = '0;
                            last_next      = 1'b0;
                        end
                        pend_vld_next = 1'b1;
                        pend_idx_next = cmp_idx_reg;
                    end
                    // table read stage
                    if (!issued_reg)
                    begin
                        note_rd_en   = 1'b1;
                        cmp_vld_next = 1'b1;
                        cmp_idx_next = rd_idx_reg;
                        rd_idx_next  = idx_inc(rd_idx_reg);
                        issued_next  = (rd_idx_reg == LAST_IDX);
                    end
                    else
                    begin
                        cmp_vld_next = 1'b0;
                        if (!cmp_vld_reg)
                        begin
                            state_next = ST_OFF_FLUSH;
                        end
                    end
                end
            end

            ST_OFF_FLUSH:
            begin
                if (!pend_vld_reg)
                begin
                    cmd_ready  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    voice_next     = VOICE_W'(pend_idx_reg);
                    gate_next      = 1'b0;
                    freq_next      = '0;
                    gain_next      = '0;
                    last_next      = 1'b1;
                    pend_vld_next  = 1'b0;
                    cmd_ready      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            wrap_reg      <= 1'b0;
            count_reg     <= FULL_CNT;
            valid_reg     <= '0;
            rd_idx_reg    <= '0;
            issued_reg    <= 1'b0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            pend_vld_reg  <= 1'b0;
            pend_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            voice_reg     <= '0;
            gate_reg      <= 1'b0;
            freq_reg      <= '0;
            gain_reg      <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            wrap_reg      <= wrap_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            rd_idx_reg    <= rd_idx_next;
            issued_reg    <= issued_next;
            cmp_vld_reg   <= cmp_vld_next;
            cmp_idx_reg   <= cmp_idx_next;
            pend_vld_reg  <= pend_vld_next;
            pend_idx_reg  <= pend_idx_next;
            out_valid_reg <= out_valid_next;
            voice_reg     <= voice_next;
            gate_reg      <= gate_next;
            freq_reg      <= freq_next;
            gain_reg      <= gain_next;
            last_reg      <= last_next;
        end
    end

    // free list memory
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            fifo_mem[tail_reg] <= cmp_idx_reg;
        end
        if (fifo_rd_en)
        begin
            fifo_q_reg <= fifo_mem[head_reg];
        end
    end

    // voice note memory
    always_ff @(posedge clk)
    begin
        if (note_wr_en)
        begin
            note_mem[pop_voice] <= cmd.note;
        end
        if (note_rd_en)
        begin
            note_q_reg <= note_mem[rd_idx_reg];
        end
    end

    assign out_valid = out_valid_reg;
    assign voice     = voice_reg;
    assign gate      = gate_reg;
    assign freq_q16  = freq_reg;
    assign gain_q15  = gain_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire
